// ----- hdl/mmlr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmlr_pkg
// Shared constants and types of the mono-mix linear resampler.
// ----------------------------------------------------------------------------
package mmlr_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int RATIO_FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MIX = 1'b1;

    typedef struct packed {
        logic final_frame;
        logic bypass;
    } t_flags;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_INTERP = 4'b0100,
        ST_TAIL   = 4'b1000
    } t_state;

endpackage

// ----- hdl/mmlr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmlr_front
// Mixes the source frame to mono or takes its left sample, and flags ratios close to one for bypass.
// ----------------------------------------------------------------------------
module mmlr_front #(
    parameter int SAMPLE_BITS     = mmlr_pkg::SAMPLE_BITS_DEF,
    parameter int RATIO_FRAC_BITS = mmlr_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0]       i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]       i_right_sample,
    input  logic                                i_final_frame,
    input  logic                                i_stereo_mix,
    input  logic        [RATIO_FRAC_BITS+3:0]   i_step_ratio,
    output logic        [SAMPLE_BITS-1:0]       o_mono,
    output mmlr_pkg::t_flags                    o_flags
);

    localparam int RATIO_W = RATIO_FRAC_BITS + 4;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;
    localparam logic [RATIO_W-1:0] BYP_LIM =
        RATIO_W'(((64'd1 << RATIO_FRAC_BITS) - 64'd1) / 64'd1000);

    logic [SAMPLE_BITS:0] mix_sum;
    logic [RATIO_W-1:0]   ratio_diff;

    assign mix_sum = {i_left_sample[SAMPLE_BITS-1], i_left_sample}
                   + {i_right_sample[SAMPLE_BITS-1], i_right_sample};

    assign o_mono = i_stereo_mix ? mix_sum[SAMPLE_BITS:1] : i_left_sample;

    assign ratio_diff = (i_step_ratio > RATIO_ONE) ? (i_step_ratio - RATIO_ONE)
                                                   : (RATIO_ONE - i_step_ratio);

    assign o_flags.final_frame = i_final_frame;
    assign o_flags.bypass      = (ratio_diff <= BYP_LIM);

endmodule

// ----- hdl/mmlr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmlr_queue
// Two-entry queue between the classifying front and the sequencing back.
// ----------------------------------------------------------------------------
module mmlr_queue #(
    parameter int WIDTH = mmlr_pkg::SAMPLE_BITS_DEF + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- hdl/mmlr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmlr_back
// Steps through the output positions of each source interval, interpolates
// one result per cycle while the output register is free, and holds it in the output register.
// ----------------------------------------------------------------------------
module mmlr_back #(
    parameter int SAMPLE_BITS     = mmlr_pkg::SAMPLE_BITS_DEF,
    parameter int RATIO_FRAC_BITS = mmlr_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_pop,
    input  logic [SAMPLE_BITS-1:0]        i_mono,
    input  mmlr_pkg::t_flags              i_flags,
    input  logic [RATIO_FRAC_BITS+3:0]    i_step_ratio,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [SAMPLE_BITS-1:0]        o_out_sample,
    output logic                          o_sample_valid,
    output logic                          o_run_last,
    output logic                          o_end_of_stream
);

    localparam int S       = SAMPLE_BITS;
    localparam int F       = RATIO_FRAC_BITS;
    localparam int RATIO_W = F + 4;
    localparam int POS_W   = F + 8;
    localparam int PROD_W  = S + F + 2;

    localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(1) << (F - 3);
    localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(1) << (F + 3);
    localparam logic [POS_W-1:0]   POS_ONE   = POS_W'(1) << F;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (F - 1);

    mmlr_pkg::t_state r_state, n_state;

    logic [S-1:0]     r_prev, n_prev;
    logic [S-1:0]     r_cur, n_cur;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_have, n_have;
    logic             r_fin, n_fin;
    logic             r_byp, n_byp;

    logic             r_out_valid;
    logic [S-1:0]     r_out_sample;
    logic             r_sample_valid;
    logic             r_run_last;
    logic             r_eos;

    logic             out_free;
    logic             emit;
    logic [S-1:0]     e_sample;
    logic             e_valid;
    logic             e_last;
    logic             e_eos;

    logic [RATIO_W-1:0] ratio;
    logic [POS_W-1:0]   pos_next;
    logic [POS_W-1:0]   pos_sub;
    logic [POS_W-1:0]   pos_next_sub;

    logic signed [S:0]        delta;
    logic signed [F:0]        frac_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] prod_shr;
    logic        [S:0]        interp_sum;
    logic        [S-1:0]      interp;

    always_comb begin
        if (i_step_ratio < RATIO_MIN) begin
            ratio = RATIO_MIN;
        end else if (i_step_ratio > RATIO_MAX) begin
            ratio = RATIO_MAX;
        end else begin
            ratio = i_step_ratio;
        end
    end

    assign pos_next     = r_pos + {{(POS_W-RATIO_W){1'b0}}, ratio};
    assign pos_sub      = r_pos - POS_ONE;
    assign pos_next_sub = pos_next - POS_ONE;

    assign delta      = $signed({r_cur[S-1], r_cur}) - $signed({r_prev[S-1], r_prev});
    assign frac_s     = $signed({1'b0, r_pos[F-1:0]});
    assign prod       = PROD_W'(delta) * PROD_W'(frac_s);
    assign prod_rnd   = prod + RND_HALF;
    assign prod_shr   = prod_rnd >>> F;
    assign interp_sum = {r_prev[S-1], r_prev} + prod_shr[S:0];
    assign interp     = interp_sum[S-1:0];

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_item_pop = (r_state == mmlr_pkg::ST_IDLE) && i_item_valid;

    always_comb begin
        n_state  = r_state;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_pos    = r_pos;
        n_have   = r_have;
        n_fin    = r_fin;
        n_byp    = r_byp;
        emit     = 1'b0;
        e_sample = r_cur;
        e_valid  = 1'b1;
        e_last   = 1'b0;
        e_eos    = 1'b0;

        unique case (r_state)
            mmlr_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    n_cur   = i_mono;
                    n_fin   = i_flags.final_frame;
                    n_byp   = i_flags.bypass;
                    n_state = mmlr_pkg::ST_RUN;
                end
            end
            mmlr_pkg::ST_RUN: begin
                if (r_byp) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_last  = 1'b1;
                        e_eos   = r_fin;
                        n_pos   = '0;
                        n_have  = 1'b0;
                        n_prev  = r_fin ? '0 : r_cur;
                        n_state = mmlr_pkg::ST_IDLE;
                    end
                end else if (!r_have) begin
                    n_prev = r_cur;
                    n_pos  = '0;
                    if (r_fin) begin
                        n_state = mmlr_pkg::ST_TAIL;
                    end else begin
                        n_have  = 1'b1;
                        n_state = mmlr_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = mmlr_pkg::ST_INTERP;
                end
            end
            mmlr_pkg::ST_INTERP: begin
                if (r_pos < POS_ONE) begin
                    if (out_free) begin
                        emit     = 1'b1;
                        e_sample = interp;
                        if (pos_next >= POS_ONE) begin
                            if (!r_fin) begin
                                e_last  = 1'b1;
                                n_pos   = pos_next_sub;
                                n_prev  = r_cur;
                                n_state = mmlr_pkg::ST_IDLE;
                            end else if (pos_next_sub < POS_ONE) begin
                                n_pos   = pos_next_sub;
                                n_prev  = r_cur;
                                n_state = mmlr_pkg::ST_TAIL;
                            end else begin
                                e_last  = 1'b1;
                                e_eos   = 1'b1;
                                n_pos   = '0;
                                n_prev  = '0;
                                n_have  = 1'b0;
                                n_state = mmlr_pkg::ST_IDLE;
                            end
                        end else begin
                            n_pos = pos_next;
                        end
                    end
                end else if (!r_fin) begin
                    n_pos   = pos_sub;
                    n_prev  = r_cur;
                    n_state = mmlr_pkg::ST_IDLE;
                end else if (pos_sub < POS_ONE) begin
                    n_pos   = pos_sub;
                    n_prev  = r_cur;
                    n_state = mmlr_pkg::ST_TAIL;
                end else if (out_free) begin
                    emit     = 1'b1;
                    e_sample = '0;
                    e_valid  = 1'b0;
                    e_last   = 1'b1;
                    e_eos    = 1'b1;
                    n_pos    = '0;
                    n_prev   = '0;
                    n_have   = 1'b0;
                    n_state  = mmlr_pkg::ST_IDLE;
                end
            end
            mmlr_pkg::ST_TAIL: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (pos_next >= POS_ONE) begin
                        e_last  = 1'b1;
                        e_eos   = 1'b1;
                        n_pos   = '0;
                        n_prev  = '0;
                        n_have  = 1'b0;
                        n_state = mmlr_pkg::ST_IDLE;
                    end else begin
                        n_pos = pos_next;
                    end
                end
            end
            default: begin
                n_state = mmlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmlr_pkg::ST_IDLE;
            r_prev      <= '0;
            r_pos       <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_pos   <= n_pos;
            r_have  <= n_have;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_fin <= n_fin;
        r_byp <= n_byp;
        if (emit) begin
            r_out_sample   <= e_sample;
            r_sample_valid <= e_valid;
            r_run_last     <= e_last;
            r_eos          <= e_eos;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_sample    = r_out_sample;
    assign o_sample_valid  = r_sample_valid;
    assign o_run_last      = r_run_last;
    assign o_end_of_stream = r_eos;

endmodule

// ----- hdl/mono_mix_linear_resampler_unit.sv -----
`timescale 1ns / 1ps
// Path: an accepted frame is written into the queue, taken by the back end in its idle state, and its
//   results are emitted into the output register from the run state in bypass, else from the
//   interpolation or tail state. The back end works on one source frame at a time and emits at most
//   16 results per frame (8 interpolated plus 8 tail results at ratio 0.125), paced by the single
//   interpolation sequencer in the back end; the two-entry queue accepts frames while it has room.
// Reset: synchronous; step_ratio returns to 1.0, stereo_mix to 1, state to idle.
// ----------------------------------------------------------------------------
// mono_mix_linear_resampler_unit
// Mono mixing linear interpolation sample rate converter with bypass.
// ----------------------------------------------------------------------------
module mono_mix_linear_resampler_unit #(
    parameter int SAMPLE_BITS     = mmlr_pkg::SAMPLE_BITS_DEF,
    parameter int RATIO_FRAC_BITS = mmlr_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mmlr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [RATIO_FRAC_BITS+3:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]      i_right_sample,
    input  logic                               i_final_frame,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_out_sample,
    output logic                               o_sample_valid,
    output logic                               o_run_last,
    output logic                               o_end_of_stream
);

    localparam int RATIO_W = RATIO_FRAC_BITS + 4;
    localparam int ITEM_W  = SAMPLE_BITS + $bits(mmlr_pkg::t_flags);
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

    logic [RATIO_W-1:0]     r_step_ratio;
    logic                   r_stereo_mix;

    logic [SAMPLE_BITS-1:0] f_mono;
    mmlr_pkg::t_flags       f_flags;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic [ITEM_W-1:0]      q_data;
    logic                   push;
    mmlr_pkg::t_flags       b_flags;
    logic [SAMPLE_BITS-1:0] b_out_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ratio <= RATIO_ONE;
            r_stereo_mix <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mmlr_pkg::CFG_STEP_RATIO: r_step_ratio <= i_cfg_data;
                mmlr_pkg::CFG_STEREO_MIX: r_stereo_mix <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mmlr_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_front (
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_final_frame  (i_final_frame),
        .i_stereo_mix   (r_stereo_mix),
        .i_step_ratio   (r_step_ratio),
        .o_mono         (f_mono),
        .o_flags        (f_flags)
    );

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    mmlr_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_mono, f_flags}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign b_flags = q_data[$bits(mmlr_pkg::t_flags)-1:0];

    mmlr_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (q_valid),
        .o_item_pop      (q_pop),
        .i_mono          (q_data[ITEM_W-1:$bits(mmlr_pkg::t_flags)]),
        .i_flags         (b_flags),
        .i_step_ratio    (r_step_ratio),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_sample    (b_out_sample),
        .o_sample_valid  (o_sample_valid),
        .o_run_last      (o_run_last),
        .o_end_of_stream (o_end_of_stream)
    );

    assign o_out_sample = b_out_sample;

endmodule

// ----- tb/sv/mmlr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmlr_checker
// Watches the config port and both streaming channels of the resampler. It
// predicts the output samples of every accepted source frame and compares
// each output transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mmlr_checker (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [mmlr_pkg::CFG_IDX_W-1:0]                i_cfg_idx,
    input  logic [mmlr_pkg::RATIO_FRAC_BITS_DEF+3:0]      i_cfg_data,
    input  logic                                          i_in_valid,
    input  logic                                          i_in_ready,
    input  logic signed [mmlr_pkg::SAMPLE_BITS_DEF-1:0]   i_left_sample,
    input  logic signed [mmlr_pkg::SAMPLE_BITS_DEF-1:0]   i_right_sample,
    input  logic                                          i_final_frame,
    input  logic                                          i_out_valid,
    input  logic                                          i_out_ready,
    input  logic signed [mmlr_pkg::SAMPLE_BITS_DEF-1:0]   i_out_sample,
    input  logic                                          i_sample_valid,
    input  logic                                          i_run_last,
    input  logic                                          i_end_of_stream,
    output int                                            o_fail_count,
    output int                                            o_pending
);

    localparam int     SW        = mmlr_pkg::SAMPLE_BITS_DEF;
    localparam int     FB        = mmlr_pkg::RATIO_FRAC_BITS_DEF;
    localparam longint UNITY     = longint'(1) << FB;
    localparam longint STEP_MIN  = UNITY >> 3;
    localparam longint STEP_MAX  = UNITY << 3;
    localparam longint HALF_FS   = longint'(1) << (SW - 1);
    localparam int     MAX_BURST = 16;
    localparam int     PRINT_CAP = 40;

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 svalid;
        logic                 rlast;
        logic                 eos;
    } t_out_item;

    logic [FB+3:0]                  step_ratio_q;
    logic                           stereo_mix_q;
    logic signed [SW-1:0]           prev_mono;
    logic [23:0]                    next_pos;
    logic                           have_prev;
    t_out_item                      expected_samples[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (o_fail_count < PRINT_CAP)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic t_out_item out_item(input logic signed [SW-1:0] s, input logic v);
        return t_out_item'{sample: s, svalid: v, rlast: 1'b0, eos: 1'b0};
    endfunction

    function automatic logic signed [SW-1:0] lerp(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b,
                                                  input logic [15:0] frac);
        longint f;
        longint acc;
        f   = longint'(frac);
        acc = longint'(a) * (UNITY - f) + longint'(b) * f + HALF_FS * UNITY + (UNITY >> 1);
        acc = (acc >>> FB) - HALF_FS;
        return acc[SW-1:0];
    endfunction

    function automatic void resample_frame(input logic signed [SW-1:0] left,
                                           input logic signed [SW-1:0] right,
                                           input logic fin);
        t_out_item            batch[$];
        t_out_item            item;
        logic signed [SW:0]   sum;
        logic signed [SW-1:0] mono;
        longint               ratio;
        longint               diff;
        longint               pos;
        sum   = {left[SW-1], left} + {right[SW-1], right};
        mono  = stereo_mix_q ? sum[SW:1] : left;
        ratio = longint'(step_ratio_q);
        diff  = (ratio > UNITY) ? ratio - UNITY : UNITY - ratio;
        if (1000 * diff < UNITY) begin
            item       = out_item(mono, 1'b1);
            item.rlast = 1'b1;
            item.eos   = fin;
            expected_samples.push_back(item);
            next_pos  = '0;
            have_prev = 1'b0;
            prev_mono = fin ? '0 : mono;
            return;
        end
        if (ratio < STEP_MIN) ratio = STEP_MIN;
        if (ratio > STEP_MAX) ratio = STEP_MAX;
        pos = longint'(next_pos);
        if (have_prev) begin
            while (pos < UNITY && batch.size() < MAX_BURST) begin
                batch.push_back(out_item(lerp(prev_mono, mono, pos[15:0]), 1'b1));
                pos = pos + ratio;
            end
            pos = pos - UNITY;
        end else begin
            pos       = 0;
            have_prev = 1'b1;
        end
        prev_mono = mono;
        if (fin) begin
            while (pos < UNITY && batch.size() < MAX_BURST) begin
                batch.push_back(out_item(mono, 1'b1));
                pos = pos + ratio;
            end
            if (batch.size() == 0)
                batch.push_back(out_item('0, 1'b0));
            batch[batch.size()-1].eos = 1'b1;
            prev_mono = '0;
            pos       = 0;
            have_prev = 1'b0;
        end
        next_pos = pos[23:0];
        if (batch.size() > 0)
            batch[batch.size()-1].rlast = 1'b1;
        foreach (batch[k])
            expected_samples.push_back(batch[k]);
    endfunction

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            step_ratio_q = UNITY[FB+3:0];
            stereo_mix_q = 1'b1;
            prev_mono    = '0;
            next_pos     = '0;
            have_prev    = 1'b0;
            expected_samples.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mmlr_pkg::CFG_STEP_RATIO: step_ratio_q = i_cfg_data;
                    mmlr_pkg::CFG_STEREO_MIX: stereo_mix_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                resample_frame(i_left_sample, i_right_sample, i_final_frame);
            if (i_out_valid && i_out_ready) begin
                got = t_out_item'{sample: i_out_sample, svalid: i_sample_valid,
                                  rlast: i_run_last, eos: i_end_of_stream};
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected output transaction", 0, longint'(got.sample));
                end else begin
                    want = expected_samples.pop_front();
                    if (got.sample !== want.sample)
                        report_mismatch("out_sample", longint'(want.sample), longint'(got.sample));
                    if (got.svalid !== want.svalid)
                        report_mismatch("sample_valid", longint'(want.svalid), longint'(got.svalid));
                    if (got.rlast !== want.rlast)
                        report_mismatch("run_last", longint'(want.rlast), longint'(got.rlast));
                    if (got.eos !== want.eos)
                        report_mismatch("end_of_stream", longint'(want.eos), longint'(got.eos));
                end
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

// ----- tb/sv/tb_mono_mix_linear_resampler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_mix_linear_resampler_unit
// Drives source frames into the resampler under several ratio and mixing
// settings: a directed pass over extremes, bypass edges, ratio clamping and
// empty end markers, then random sources with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_mono_mix_linear_resampler_unit;

    localparam int SW             = mmlr_pkg::SAMPLE_BITS_DEF;
    localparam int RW             = mmlr_pkg::RATIO_FRAC_BITS_DEF + 4;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_FRAMES  = 460;
    localparam int PHASE_FRAMES   = 24;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           cfg_we      = 1'b0;
    logic [mmlr_pkg::CFG_IDX_W-1:0] cfg_idx     = mmlr_pkg::CFG_STEP_RATIO;
    logic [RW-1:0]                  cfg_data    = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_ready;
    logic signed [SW-1:0]           left_sample  = '0;
    logic signed [SW-1:0]           right_sample = '0;
    logic                           final_frame  = 1'b0;
    logic                           out_valid;
    logic                           out_ready   = 1'b0;
    logic signed [SW-1:0]           out_sample;
    logic                           sample_valid;
    logic                           run_last;
    logic                           end_of_stream;

    int fail_count;
    int pending_results;
    int tx_idle_pct   = 27;
    int rx_idle_pct   = 51;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int random_sent   = 0;
    int cycle_count   = 0;

    mono_mix_linear_resampler_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_left_sample   (left_sample),
        .i_right_sample  (right_sample),
        .i_final_frame   (final_frame),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_out_sample    (out_sample),
        .o_sample_valid  (sample_valid),
        .o_run_last      (run_last),
        .o_end_of_stream (end_of_stream)
    );

    mmlr_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_left_sample   (left_sample),
        .i_right_sample  (right_sample),
        .i_final_frame   (final_frame),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_out_sample    (out_sample),
        .i_sample_valid  (sample_valid),
        .i_run_last      (run_last),
        .i_end_of_stream (end_of_stream),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left   = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic write_reg(input logic [mmlr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [RW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_frame(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                              input logic fin);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(negedge clk);
        end
        in_valid     <= 1'b1;
        left_sample  <= l;
        right_sample <= r;
        final_frame  <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic play_source(input int frames);
        for (int k = 0; k < frames; k++) begin
            if (random_sent < RANDOM_FRAMES / 3) begin
                tx_idle_pct = 27;
                rx_idle_pct = 51;
            end else if (random_sent < 2 * RANDOM_FRAMES / 3) begin
                tx_idle_pct = 51;
                rx_idle_pct = 27;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_frame(pick_sample(), pick_sample(), k == frames - 1);
            random_sent = random_sent + 1;
        end
    endtask

    initial begin
        logic [RW-1:0] ratio;
        int            phase_frames;
        int            len;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bypass at the reset ratio, stereo extremes
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(-16'sd1, 16'sd0, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1);
        settle();

        // half step, left only
        write_reg(mmlr_pkg::CFG_STEP_RATIO, RW'(32768));
        write_reg(mmlr_pkg::CFG_STEREO_MIX, RW'(0));
        send_frame(16'sh8000, 16'sh7FFF, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sd0, 16'sd0, 1'b0);
        send_frame(16'sh8000, 16'sd1, 1'b1);
        settle();

        // ratio below range clamps to the densest output
        write_reg(mmlr_pkg::CFG_STEP_RATIO, RW'(0));
        write_reg(mmlr_pkg::CFG_STEREO_MIX, RW'(1));
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_frame(16'sh8000, 16'sh8000, 1'b1);
        settle();

        // ratio above range clamps, final frame yields the empty end marker
        write_reg(mmlr_pkg::CFG_STEP_RATIO, {RW{1'b1}});
        send_frame(16'sd100, -16'sd100, 1'b0);
        send_frame(16'sd5, 16'sd7, 1'b0);
        send_frame(-16'sd9, -16'sd3, 1'b1);
        send_frame(16'sd1234, -16'sd1, 1'b1);
        send_frame(16'sd300, 16'sd301, 1'b0);
        send_frame(16'sd302, 16'sd303, 1'b0);
        settle();

        // just inside the bypass window drops the pending position
        write_reg(mmlr_pkg::CFG_STEP_RATIO, RW'(65536 + 65));
        send_frame(16'sd7, 16'sd8, 1'b0);
        send_frame(-16'sd7, -16'sd8, 1'b1);
        settle();

        // just outside the bypass window
        write_reg(mmlr_pkg::CFG_STEP_RATIO, RW'(65536 + 66));
        send_frame(16'sd10, 16'sd20, 1'b0);
        send_frame(16'sd30, 16'sd40, 1'b1);

        for (int ph = 0; random_sent < RANDOM_FRAMES; ph++) begin
            settle();
            case ($urandom_range(0, 11))
                0:       ratio = RW'(8192);
                1:       ratio = RW'(524288);
                2:       ratio = RW'(65536);
                3:       ratio = RW'(0);
                4:       ratio = {RW{1'b1}};
                5:       ratio = RW'(65536 - $urandom_range(0, 70));
                6:       ratio = RW'(65536 + $urandom_range(0, 70));
                7:       ratio = RW'($urandom_range(0, 20'hFFFFF));
                default: ratio = RW'($urandom_range(8192, 524288));
            endcase
            write_reg(mmlr_pkg::CFG_STEP_RATIO, ratio);
            write_reg(mmlr_pkg::CFG_STEREO_MIX, RW'($urandom_range(0, 1)));
            if (ph == 2 || ph == 14)
                hold_requests = hold_requests + 1;
            phase_frames = 0;
            while (phase_frames < PHASE_FRAMES) begin
                len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
                play_source(len);
                phase_frames = phase_frames + len;
            end
        end

        settle();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mmlr_pkg.sv
hdl/mmlr_front.sv
hdl/mmlr_queue.sv
hdl/mmlr_back.sv
hdl/mono_mix_linear_resampler_unit.sv
tb/sv/mmlr_checker.sv
tb/sv/tb_mono_mix_linear_resampler_unit.sv
